@@ rtl/core/lbachs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbachs_pkg
// Types and constants shared by the logical block to CHS read splitter.
// ----------------------------------------------------------------------------
package lbachs_pkg;

  typedef struct packed {
    logic [31:0] start_block;
    logic [6:0]  sector_count;
  } req_t;

  typedef struct packed {
    logic [9:0] cylinder;
    logic [7:0] head;
    logic [5:0] sector;
    logic [3:0] chunk_sectors;
    logic [5:0] buffer_offset;
    logic       range_error;
    logic       last;
  } chunk_t;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_SECTORS_PER_TRACK = 2'd0;
  localparam cfg_index_t CFG_HEAD_COUNT        = 2'd1;
  localparam cfg_index_t CFG_CYLINDER_COUNT    = 2'd2;

  localparam int CFG_DATA_W = 11;

  localparam logic [5:0]  SPT_RESET   = 6'd63;
  localparam logic [7:0]  HEADS_RESET = 8'd255;
  localparam logic [10:0] CYLS_RESET  = 11'd1024;

  localparam int          HW_CHUNK_CAP    = 127;
  localparam logic [10:0] CYL_FIELD_LIMIT = 11'd1024;

endpackage

@@ rtl/core/lba_to_chs_read_splitter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lba_to_chs_read_splitter_core
// Splits a disk read request into track-bounded chunks and converts each
// chunk's block to cylinder, head and sector with one shared serial divider.
// ----------------------------------------------------------------------------
// chunk steps: setup, 32-step divide by sectors per track, 32-step divide by
//   heads, issue; the issue step waits while the output stalls
// one request at a time: a new request waits until its last chunk has issued;
//   each chunk from a valid geometry runs through the serial restoring divider
// a zero-geometry request skips the divider and goes from setup to issue of its error transfer
// reset: control and output valid cleared, geometry back to 63 / 255 / 1024
module lba_to_chs_read_splitter_core #(
  parameter int CHUNK_SECTORS = 8,
  parameter int MAX_REQUEST   = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  lbachs_pkg::req_t                    req_data,
  output logic                                chunk_valid,
  input  logic                                chunk_stall,
  output lbachs_pkg::chunk_t                  chunk_data,
  input  logic                                cfg_we,
  input  lbachs_pkg::cfg_index_t              cfg_index,
  input  logic [lbachs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CAP_INT = (CHUNK_SECTORS < lbachs_pkg::HW_CHUNK_CAP) ?
                           CHUNK_SECTORS : lbachs_pkg::HW_CHUNK_CAP;
  localparam logic [6:0] CHUNK_CAP = 7'(CAP_INT);
  localparam logic [6:0] REQ_MAX   = 7'(MAX_REQUEST);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_SPT,
    ST_DIV_HEAD,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [5:0]  spt;
  logic [7:0]  heads;
  logic [10:0] cyls;

  logic [31:0] block;
  logic [6:0]  left;
  logic [5:0]  offset;
  logic        geo_err;
  logic [5:0]  sec0;

  // shared divider
  logic [31:0] quo;
  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic [4:0]  cnt;

  logic [8:0]  shifted;
  logic [7:0]  diff;
  logic        ge;
  logic [31:0] step_q;
  logic [7:0]  step_r;

  logic [10:0] limit;
  logic        cyl_over;
  logic        chunk_err;
  logic [6:0]  n_cap;
  logic [7:0]  end_sum;
  logic [6:0]  n;
  logic [6:0]  left_next;
  logic [6:0]  count_sat;
  logic        out_free;

  assign shifted = {rem, quo[31]};
  assign diff    = shifted[7:0] - dvs;
  assign ge      = shifted >= {1'b0, dvs};
  assign step_r  = ge ? diff : shifted[7:0];
  assign step_q  = {quo[30:0], ge};

  assign limit     = (cyls < lbachs_pkg::CYL_FIELD_LIMIT) ? cyls : lbachs_pkg::CYL_FIELD_LIMIT;
  assign cyl_over  = (|quo[31:11]) || (quo[10:0] >= limit);
  assign chunk_err = geo_err || cyl_over;

  assign n_cap     = (left < CHUNK_CAP) ? left : CHUNK_CAP;
  assign end_sum   = {2'b00, sec0} + {1'b0, n_cap};
  assign n         = (end_sum > {2'b00, spt}) ? {1'b0, spt - sec0} : n_cap;
  assign left_next = left - n;

  assign count_sat = (req_data.sector_count > REQ_MAX) ? REQ_MAX : req_data.sector_count;
  assign out_free  = !chunk_valid || !chunk_stall;
  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      spt         <= lbachs_pkg::SPT_RESET;
      heads       <= lbachs_pkg::HEADS_RESET;
      cyls        <= lbachs_pkg::CYLS_RESET;
      chunk_valid <= 1'b0;
      geo_err     <= 1'b0;
      left        <= '0;
      offset      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lbachs_pkg::CFG_SECTORS_PER_TRACK: spt   <= cfg_data[5:0];
          lbachs_pkg::CFG_HEAD_COUNT:        heads <= cfg_data[7:0];
          lbachs_pkg::CFG_CYLINDER_COUNT:    cyls  <= cfg_data;
          default: ;
        endcase
      end

      if (chunk_valid && !chunk_stall && state != ST_EMIT) begin
        chunk_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            block  <= req_data.start_block;
            left   <= count_sat;
            offset <= '0;
            if (count_sat != 7'd0) begin
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          if (spt == 6'd0 || heads == 8'd0) begin
            geo_err <= 1'b1;
            state   <= ST_EMIT;
          end else begin
            quo   <= block;
            rem   <= '0;
            dvs   <= {2'b00, spt};
            cnt   <= '1;
            state <= ST_DIV_SPT;
          end
        end
        ST_DIV_SPT: begin
          quo <= step_q;
          if (cnt == 5'd0) begin
            sec0  <= step_r[5:0];
            rem   <= '0;
            dvs   <= heads;
            cnt   <= '1;
            state <= ST_DIV_HEAD;
          end else begin
            rem <= step_r;
            cnt <= cnt - 5'd1;
          end
        end
        ST_DIV_HEAD: begin
          quo <= step_q;
          rem <= step_r;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            chunk_valid              <= 1'b1;
            chunk_data.buffer_offset <= offset;
            if (chunk_err) begin
              chunk_data.cylinder      <= '0;
              chunk_data.head          <= '0;
              chunk_data.sector        <= '0;
              chunk_data.chunk_sectors <= '0;
              chunk_data.range_error   <= 1'b1;
              chunk_data.last          <= 1'b1;
              geo_err                  <= 1'b0;
              left                     <= '0;
              state                    <= ST_IDLE;
            end else begin
              chunk_data.cylinder      <= quo[9:0];
              chunk_data.head          <= rem;
              chunk_data.sector        <= sec0 + 6'd1;
              chunk_data.chunk_sectors <= n[3:0];
              chunk_data.range_error   <= 1'b0;
              chunk_data.last          <= (left_next == 7'd0);
              left                     <= left_next;
              block                    <= block + 32'(n);
              offset                   <= offset + n[5:0];
              state                    <= (left_next == 7'd0) ? ST_IDLE : ST_START;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // error transfer always closes the request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && chunk_data.range_error |-> chunk_data.last)
    else $error("range error transfer without last");

  // a good chunk starts on a sector inside the track
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    chunk_valid && !chunk_data.range_error |->
      chunk_data.sector != 6'd0 && chunk_data.sector <= spt)
    else $error("chunk sector outside track");

  // a new chunk is only started with sectors still outstanding
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_START |-> left != 7'd0)
    else $error("chunk started with nothing left");

  // divider phases always run their full step count
  a_div_handoff: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV_SPT && cnt == 5'd0 |=> state == ST_DIV_HEAD && cnt == 5'd31)
    else $error("divider handoff broken");

endmodule
